// ===== design/pba_pkg.sv =====
package pba_pkg;

  localparam int unsigned MAX_PAGE_COUNT_DEF = 65536;
  localparam int unsigned REGION_SLOTS_DEF   = 64;

  // page numbers of a 32-bit address space, plus one bit for the round-up case
  localparam int unsigned PAGE_W = 21;

  localparam logic [31:0]       LOW_LIMIT        = 32'h0010_0000;
  localparam logic [21:0]       STACK_TOP        = 22'h09_0000;
  localparam logic [PAGE_W-1:0] KERNEL_FIRST_PG  = 21'd16;
  localparam logic [PAGE_W-1:0] ALLOC_FIRST_PG   = 21'd256;
  localparam logic [31:0]       USABLE_TYPE      = 32'd1;

  typedef enum logic [2:0] {
    ACT_BEGIN = 3'd0,
    ACT_ADD   = 3'd1,
    ACT_BUILD = 3'd2,
    ACT_ALLOC = 3'd3,
    ACT_FREE  = 3'd4
  } action_e;

  typedef enum logic [3:0] {
    ST_OK         = 4'd0,
    ST_NO_MEM     = 4'd1,
    ST_UNALIGNED  = 4'd2,
    ST_BAD_ADDR   = 4'd3,
    ST_KERNEL     = 4'd4,
    ST_NOT_USABLE = 4'd5,
    ST_DBL_FREE   = 4'd6,
    ST_TABLE_FULL = 4'd7,
    ST_MAP_STACK  = 4'd8
  } status_e;

  // bits of map word w whose page lies in [lo, hi)
  function automatic logic [31:0] word_mask(input logic [15:0] w,
                                            input logic [PAGE_W-1:0] lo,
                                            input logic [PAGE_W-1:0] hi);
    logic [PAGE_W-1:0] pg;
    logic [31:0]       m;
    m = '0;
    for (int b = 0; b < 32; b++) begin
      pg   = {w, 5'(b)};
      m[b] = (pg >= lo) && (pg < hi);
    end
    return m;
  endfunction

endpackage

// ===== design/pba_map_ram.sv =====
module pba_map_ram #(
  parameter int unsigned DEPTH = 2048,
  parameter int unsigned AW    = 11
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [31:0]   wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [31:0]   rdata_o
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== design/pba_region_ram.sv =====
module pba_region_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [63:0]   wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [63:0]   rdata_o
);

  // each entry is {start, end}
  logic [63:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== design/page_bitmap_allocator.sv =====
// Physical page allocator, 4 KiB pages, one used bit per page held in a
// 32-bit-wide map RAM, regions in a separate table RAM. Every action gives
// one result. Begin, add_region and undefined actions go straight from idle
// to the result. Alloc reads and checks one map word at a time from page 256
// up. Free walks the region table one region at a time until a hit, then
// reads and checks the map word. Build rewrites the whole map with ones, then
// clears the pages of each region, one map word at a time, then sets the
// kernel pages in the same way. After reset the map is filled with ones
// before the first input transaction is taken.
module page_bitmap_allocator #(
  parameter int unsigned MAX_PAGE_COUNT = pba_pkg::MAX_PAGE_COUNT_DEF,
  parameter int unsigned REGION_SLOTS   = pba_pkg::REGION_SLOTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [19:0] cfg_kernel_end_address_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  action_i,
  input  logic [31:0] region_type_i,
  input  logic [63:0] region_start_i,
  input  logic [63:0] region_length_i,
  input  logic [31:0] free_address_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  status_o,
  output logic [31:0] page_address_o,
  output logic [16:0] total_pages_o
);
  import pba_pkg::*;

  localparam int unsigned MAP_WORDS = (MAX_PAGE_COUNT + 31) / 32;
  localparam int unsigned WIDX_W    = $clog2(MAP_WORDS);
  localparam int unsigned CNT_W     = $clog2(REGION_SLOTS + 1);
  localparam int unsigned RIDX_W    = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;

  localparam logic [PAGE_W-1:0] MAX_PG    = PAGE_W'(MAX_PAGE_COUNT);
  localparam logic [CNT_W-1:0]  SLOTS_C   = CNT_W'(REGION_SLOTS);
  localparam logic [WIDX_W-1:0] LAST_WORD = WIDX_W'(MAP_WORDS - 1);

  localparam logic [3:0] S_INIT      = 4'd0;
  localparam logic [3:0] S_IDLE      = 4'd1;
  localparam logic [3:0] S_FILL      = 4'd2;
  localparam logic [3:0] S_RG_RD     = 4'd3;
  localparam logic [3:0] S_RG_CHK    = 4'd4;
  localparam logic [3:0] S_BIT_RD    = 4'd5;
  localparam logic [3:0] S_BIT_WR    = 4'd6;
  localparam logic [3:0] S_AL_RD     = 4'd7;
  localparam logic [3:0] S_AL_CHK    = 4'd8;
  localparam logic [3:0] S_FR_RG_RD  = 4'd9;
  localparam logic [3:0] S_FR_RG_CHK = 4'd10;
  localparam logic [3:0] S_FR_RD     = 4'd11;
  localparam logic [3:0] S_FR_CHK    = 4'd12;
  localparam logic [3:0] S_DONE      = 4'd13;

  logic [3:0]        state_q, state_d;
  logic [19:0]       ked_q;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [31:0]       highest_q, highest_d;
  logic [PAGE_W-1:0] limit_q, limit_d;
  logic [CNT_W-1:0]  r_q, r_d;
  logic [WIDX_W-1:0] w_q, w_d;
  logic [PAGE_W-1:0] lo_q, lo_d, hi_q, hi_d;
  logic              kern_q, kern_d;
  logic [19:0]       p_q, p_d;
  logic [3:0]        res_status_q, res_status_d;
  logic [31:0]       res_addr_q, res_addr_d;
  logic              out_valid_q;
  logic [3:0]        out_status_q;
  logic [31:0]       out_addr_q;
  logic [16:0]       out_total_q;

  logic        map_we;
  logic [31:0] map_wdata, map_rdata;
  logic        rg_we;
  logic [63:0] rg_wdata, rg_rdata;

  pba_map_ram #(.DEPTH(MAP_WORDS), .AW(WIDX_W)) u_map (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (w_q),
    .wdata_i (map_wdata),
    .raddr_i (w_q),
    .rdata_o (map_rdata)
  );

  pba_region_ram #(.DEPTH(REGION_SLOTS), .AW(RIDX_W)) u_region (
    .clk_i   (clk_i),
    .we_i    (rg_we),
    .waddr_i (cnt_q[RIDX_W-1:0]),
    .wdata_i (rg_wdata),
    .raddr_i (r_q[RIDX_W-1:0]),
    .rdata_o (rg_rdata)
  );

  // add_region arithmetic
  logic [64:0] add_sum;
  logic [63:0] add_end, add_base;
  logic [31:0] end32, base32;
  logic        add_keep;
  assign add_sum  = {1'b0, region_start_i} + {1'b0, region_length_i};
  assign add_end  = add_sum[64] ? '1 : add_sum[63:0];
  assign add_base = (region_start_i < 64'(LOW_LIMIT)) ? 64'(LOW_LIMIT) : region_start_i;
  assign end32    = (add_end[63:32] != '0) ? '1 : add_end[31:0];
  assign base32   = (add_base[63:32] != '0) ? '1 : add_base[31:0];
  assign add_keep = (region_type_i == USABLE_TYPE) && (add_end > 64'(LOW_LIMIT));
  assign rg_wdata = {base32, end32};

  // kernel span and map placement
  logic [PAGE_W-1:0] ked_sum, klast, khi, lim_raw, lim_new, mstart;
  logic [21:0]       map_end;
  assign ked_sum = {1'b0, ked_q} + PAGE_W'(4095);
  assign klast   = {12'd0, ked_sum[20:12]};
  assign khi     = (klast < limit_q) ? klast : limit_q;
  assign lim_raw = {1'b0, highest_q[31:12]};
  assign lim_new = (lim_raw > MAX_PG) ? MAX_PG : lim_raw;
  assign mstart  = {ked_sum[20:12], 12'd0};
  assign map_end = {1'b0, mstart} + {1'b0, lim_new};

  // region entry as read back
  logic [32:0]       rg_first_sum;
  logic [PAGE_W-1:0] rg_lo, rg_e, rg_hi;
  logic              rg_last;
  assign rg_first_sum = {1'b0, rg_rdata[63:32]} + 33'd4095;
  assign rg_lo   = rg_first_sum[32:12];
  assign rg_e    = {1'b0, rg_rdata[31:12]};
  assign rg_hi   = (rg_e < limit_q) ? rg_e : limit_q;
  assign rg_last = ((r_q + CNT_W'(1)) == cnt_q);

  // word range walk
  logic [PAGE_W-1:0] hi_m1, lim_m1;
  logic [WIDX_W-1:0] last_w, al_last_w;
  logic [31:0]       span_mask, al_mask, avail, pick;
  logic              found;
  logic [4:0]        pick_bit;
  assign hi_m1     = hi_q - PAGE_W'(1);
  assign lim_m1    = limit_q - PAGE_W'(1);
  assign last_w    = hi_m1[5 +: WIDX_W];
  assign al_last_w = lim_m1[5 +: WIDX_W];
  assign span_mask = word_mask(16'(w_q), lo_q, hi_q);
  assign al_mask   = word_mask(16'(w_q), ALLOC_FIRST_PG, limit_q);
  assign avail     = ~map_rdata & al_mask;

  always_comb begin
    found    = 1'b0;
    pick_bit = '0;
    for (int b = 0; b < 32; b++) begin
      if (avail[b] && !found) begin
        found    = 1'b1;
        pick_bit = 5'(b);
      end
    end
    pick = 32'd1 << pick_bit;
  end

  // free address checks
  logic [19:0] fr_page;
  logic        fr_hit;
  assign fr_page = free_address_i[31:12];
  assign fr_hit  = ({1'b0, p_q} >= rg_lo) && ({1'b0, p_q} < rg_e);

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    highest_d    = highest_q;
    limit_d      = limit_q;
    r_d          = r_q;
    w_d          = w_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    kern_d       = kern_q;
    p_d          = p_q;
    res_status_d = res_status_q;
    res_addr_d   = res_addr_q;
    map_we       = 1'b0;
    map_wdata    = '1;
    rg_we        = 1'b0;

    case (state_q)
      S_INIT: begin
        map_we = 1'b1;
        if (w_q == LAST_WORD) begin
          w_d     = '0;
          state_d = S_IDLE;
        end else begin
          w_d = w_q + WIDX_W'(1);
        end
      end

      S_IDLE: begin
        if (in_valid_i) begin
          res_status_d = ST_OK;
          res_addr_d   = '0;
          state_d      = S_DONE;
          case (action_i)
            ACT_BEGIN: begin
              cnt_d     = '0;
              highest_d = LOW_LIMIT;
            end
            ACT_ADD: begin
              if (add_keep) begin
                if (cnt_q >= SLOTS_C) begin
                  res_status_d = ST_TABLE_FULL;
                end else begin
                  rg_we = 1'b1;
                  cnt_d = cnt_q + CNT_W'(1);
                  if (end32 > highest_q) begin
                    highest_d = end32;
                  end
                end
              end
            end
            ACT_BUILD: begin
              limit_d      = lim_new;
              res_status_d = (map_end >= STACK_TOP) ? ST_MAP_STACK : ST_OK;
              w_d          = '0;
              state_d      = S_FILL;
            end
            ACT_ALLOC: begin
              if (limit_q > ALLOC_FIRST_PG) begin
                w_d     = ALLOC_FIRST_PG[5 +: WIDX_W];
                state_d = S_AL_RD;
              end else begin
                res_status_d = ST_NO_MEM;
              end
            end
            ACT_FREE: begin
              p_d = fr_page;
              r_d = '0;
              if (free_address_i[11:0] != '0) begin
                res_status_d = ST_UNALIGNED;
              end else if (free_address_i < LOW_LIMIT ||
                           {1'b0, fr_page} >= limit_q) begin
                res_status_d = ST_BAD_ADDR;
              end else if ({1'b0, fr_page} >= KERNEL_FIRST_PG &&
                           {1'b0, fr_page} < klast) begin
                res_status_d = ST_KERNEL;
              end else if (cnt_q == '0) begin
                res_status_d = ST_NOT_USABLE;
              end else begin
                state_d = S_FR_RG_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_FILL: begin
        map_we = 1'b1;
        if (w_q == LAST_WORD) begin
          r_d = '0;
          if (cnt_q != '0) begin
            state_d = S_RG_RD;
          end else if (KERNEL_FIRST_PG < khi) begin
            lo_d    = KERNEL_FIRST_PG;
            hi_d    = khi;
            kern_d  = 1'b1;
            w_d     = KERNEL_FIRST_PG[5 +: WIDX_W];
            state_d = S_BIT_RD;
          end else begin
            state_d = S_DONE;
          end
        end else begin
          w_d = w_q + WIDX_W'(1);
        end
      end

      S_RG_RD: begin
        state_d = S_RG_CHK;
      end

      S_RG_CHK: begin
        if (rg_lo < rg_hi) begin
          lo_d    = rg_lo;
          hi_d    = rg_hi;
          kern_d  = 1'b0;
          w_d     = rg_lo[5 +: WIDX_W];
          state_d = S_BIT_RD;
        end else if (!rg_last) begin
          r_d     = r_q + CNT_W'(1);
          state_d = S_RG_RD;
        end else if (KERNEL_FIRST_PG < khi) begin
          lo_d    = KERNEL_FIRST_PG;
          hi_d    = khi;
          kern_d  = 1'b1;
          w_d     = KERNEL_FIRST_PG[5 +: WIDX_W];
          state_d = S_BIT_RD;
        end else begin
          state_d = S_DONE;
        end
      end

      S_BIT_RD: begin
        state_d = S_BIT_WR;
      end

      S_BIT_WR: begin
        map_we    = 1'b1;
        map_wdata = kern_q ? (map_rdata | span_mask) : (map_rdata & ~span_mask);
        if (w_q != last_w) begin
          w_d     = w_q + WIDX_W'(1);
          state_d = S_BIT_RD;
        end else if (kern_q) begin
          state_d = S_DONE;
        end else if (!rg_last) begin
          r_d     = r_q + CNT_W'(1);
          state_d = S_RG_RD;
        end else if (KERNEL_FIRST_PG < khi) begin
          lo_d    = KERNEL_FIRST_PG;
          hi_d    = khi;
          kern_d  = 1'b1;
          w_d     = KERNEL_FIRST_PG[5 +: WIDX_W];
          state_d = S_BIT_RD;
        end else begin
          state_d = S_DONE;
        end
      end

      S_AL_RD: begin
        state_d = S_AL_CHK;
      end

      S_AL_CHK: begin
        if (found) begin
          map_we       = 1'b1;
          map_wdata    = map_rdata | pick;
          res_addr_d   = 32'({w_q, pick_bit}) << 12;
          state_d      = S_DONE;
        end else if (w_q == al_last_w) begin
          res_status_d = ST_NO_MEM;
          state_d      = S_DONE;
        end else begin
          w_d     = w_q + WIDX_W'(1);
          state_d = S_AL_RD;
        end
      end

      S_FR_RG_RD: begin
        state_d = S_FR_RG_CHK;
      end

      S_FR_RG_CHK: begin
        if (fr_hit) begin
          w_d     = p_q[5 +: WIDX_W];
          state_d = S_FR_RD;
        end else if (!rg_last) begin
          r_d     = r_q + CNT_W'(1);
          state_d = S_FR_RG_RD;
        end else begin
          res_status_d = ST_NOT_USABLE;
          state_d      = S_DONE;
        end
      end

      S_FR_RD: begin
        state_d = S_FR_CHK;
      end

      S_FR_CHK: begin
        if (!map_rdata[p_q[4:0]]) begin
          res_status_d = ST_DBL_FREE;
        end else begin
          map_we    = 1'b1;
          map_wdata = map_rdata & ~(32'd1 << p_q[4:0]);
        end
        state_d = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      ked_q       <= 20'h2_0000;
      cnt_q       <= '0;
      highest_q   <= LOW_LIMIT;
      limit_q     <= '0;
      r_q         <= '0;
      w_q         <= '0;
      kern_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      highest_q <= highest_d;
      limit_q   <= limit_d;
      r_q       <= r_d;
      w_q       <= w_d;
      kern_q    <= kern_d;
      if (cfg_valid_i) begin
        ked_q <= cfg_kernel_end_address_i;
      end
      if (state_q == S_DONE && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    p_q          <= p_d;
    res_status_q <= res_status_d;
    res_addr_q   <= res_addr_d;
    if (state_q == S_DONE && (!out_valid_q || out_ready_i)) begin
      out_status_q <= res_status_q;
      out_addr_q   <= res_addr_q;
      out_total_q  <= limit_q[16:0];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign page_address_o = out_addr_q;
  assign total_pages_o  = out_total_q;

`ifndef SYNTHESIS
  a_addr_only_on_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && page_address_o != '0 |-> status_o == ST_OK && page_address_o >= LOW_LIMIT)
    else $error("allocated address with bad status or below 1 MiB");

  a_addr_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> page_address_o[11:0] == '0)
    else $error("allocated address not page aligned");

  a_region_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= SLOTS_C)
    else $error("region count above table size");

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("new transaction taken before result produced");
`endif

endmodule

// ===== dv/tb_page_bitmap_allocator.sv =====
module tb_page_bitmap_allocator;
  timeunit 1ns;
  timeprecision 1ps;
  import pba_pkg::*;

  localparam int unsigned N_ITEMS    = 1500;
  localparam int unsigned IDLE_LIMIT = 2000000;

  typedef struct {
    logic [2:0]  act;
    logic [31:0] rtype;
    logic [63:0] start;
    logic [63:0] len;
    logic [31:0] addr;
    bit          known;
    status_e     st;
    logic [31:0] pa;
    logic [16:0] tp;
  } op_t;

  typedef struct {
    status_e     st;
    logic [31:0] pa;
    logic [16:0] tp;
  } result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [19:0] cfg_kernel_end_address_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  action_i = '0;
  logic [31:0] region_type_i = '0;
  logic [63:0] region_start_i = '0;
  logic [63:0] region_length_i = '0;
  logic [31:0] free_address_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [3:0]  status_o;
  logic [31:0] page_address_o;
  logic [16:0] total_pages_o;

  page_bitmap_allocator dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_kernel_end_address_i,
    .in_valid_i, .in_ready_o, .action_i, .region_type_i, .region_start_i,
    .region_length_i, .free_address_i, .out_valid_o, .out_ready_i,
    .status_o, .page_address_o, .total_pages_o
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // allocator state as predicted
  logic [19:0] kernel_end;
  logic [31:0] reg_lo [REGION_SLOTS_DEF];
  logic [31:0] reg_hi [REGION_SLOTS_DEF];
  int unsigned n_regions;
  logic [31:0] top_addr;
  int unsigned page_lim;
  bit          page_used [MAX_PAGE_COUNT_DEF];

  result_t     pending_results [$];
  logic [31:0] granted_pages [$];
  int unsigned sent, received, mismatches;
  int unsigned n_alloc_ok, n_free_ok, n_oom, n_full, n_stack, n_reject;

  function automatic int unsigned first_pg(input logic [31:0] lo);
    return int'((64'(lo) + 64'd4095) >> 12);
  endfunction

  function automatic int unsigned kernel_last_pg();
    return (int'(kernel_end) + 4095) >> 12;
  endfunction

  function automatic void apply_op(input op_t op, output result_t r);
    logic [64:0]     sum;
    longint unsigned base, fin;
    int unsigned     lim, pg, e;
    bit              hit;
    r.st = ST_OK;
    r.pa = '0;
    case (op.act)
      ACT_BEGIN: begin
        n_regions = 0;
        top_addr  = LOW_LIMIT;
      end
      ACT_ADD: begin
        sum = {1'b0, op.start} + {1'b0, op.len};
        fin = sum[64] ? '1 : sum[63:0];
        if (op.rtype == USABLE_TYPE && fin > 64'(LOW_LIMIT)) begin
          base = (op.start < 64'(LOW_LIMIT)) ? 64'(LOW_LIMIT) : op.start;
          if (n_regions >= REGION_SLOTS_DEF) begin
            r.st = ST_TABLE_FULL;
          end else begin
            reg_lo[n_regions] = (base > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : base[31:0];
            reg_hi[n_regions] = (fin > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : fin[31:0];
            if (reg_hi[n_regions] > top_addr) top_addr = reg_hi[n_regions];
            n_regions++;
          end
        end
      end
      ACT_BUILD: begin
        lim = top_addr >> 12;
        if (lim > MAX_PAGE_COUNT_DEF) lim = MAX_PAGE_COUNT_DEF;
        page_lim = lim;
        foreach (page_used[i]) page_used[i] = 1'b1;
        for (int unsigned k = 0; k < n_regions; k++) begin
          e = reg_hi[k] >> 12;
          for (int unsigned p = first_pg(reg_lo[k]); p < e && p < lim; p++)
            page_used[p] = 1'b0;
        end
        for (int unsigned p = KERNEL_FIRST_PG; p < kernel_last_pg() && p < lim; p++)
          page_used[p] = 1'b1;
        if (((longint'(kernel_end) + 4095) & ~longint'(4095)) + lim >= longint'(STACK_TOP))
          r.st = ST_MAP_STACK;
      end
      ACT_ALLOC: begin
        r.st = ST_NO_MEM;
        for (int unsigned p = ALLOC_FIRST_PG; p < page_lim; p++) begin
          if (!page_used[p]) begin
            page_used[p] = 1'b1;
            r.pa = p << 12;
            r.st = ST_OK;
            break;
          end
        end
      end
      ACT_FREE: begin
        pg = op.addr >> 12;
        hit = 1'b0;
        for (int unsigned k = 0; k < n_regions; k++)
          if (pg >= first_pg(reg_lo[k]) && pg < (reg_hi[k] >> 12)) hit = 1'b1;
        if (op.addr[11:0] != 0) r.st = ST_UNALIGNED;
        else if (op.addr < LOW_LIMIT || pg >= page_lim) r.st = ST_BAD_ADDR;
        else if (pg >= KERNEL_FIRST_PG && pg < kernel_last_pg()) r.st = ST_KERNEL;
        else if (!hit) r.st = ST_NOT_USABLE;
        else if (!page_used[pg]) r.st = ST_DBL_FREE;
        else page_used[pg] = 1'b0;
      end
      default: ;
    endcase
    r.tp = page_lim[16:0];
    if (op.act == ACT_ALLOC && r.st == ST_OK) begin
      n_alloc_ok++;
      granted_pages.push_back(r.pa);
    end
    if (op.act == ACT_FREE) begin
      if (r.st == ST_OK) n_free_ok++;
      else n_reject++;
    end
    if (r.st == ST_NO_MEM) n_oom++;
    if (r.st == ST_TABLE_FULL) n_full++;
    if (r.st == ST_MAP_STACK) n_stack++;
  endfunction

  function automatic op_t mk_op(input logic [2:0] act, input logic [31:0] rtype,
                                input logic [63:0] start, input logic [63:0] len,
                                input logic [31:0] addr);
    op_t o;
    o.act = act; o.rtype = rtype; o.start = start; o.len = len; o.addr = addr;
    o.known = 1'b0; o.st = ST_OK; o.pa = '0; o.tp = '0;
    return o;
  endfunction

  function automatic op_t mk_known(input op_t o, input status_e st);
    op_t k;
    k = o;
    k.known = 1'b1; k.st = st; k.pa = '0; k.tp = '0;
    return k;
  endfunction

  function automatic int unsigned pick_gap();
    if ((sent / 200) % 4 == 1) return 0;
    if ($urandom_range(0, 3) != 0) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(20, 60);
    return $urandom_range(1, 3);
  endfunction

  task automatic send_op(input op_t op);
    int unsigned gap;
    result_t     r;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    action_i        <= op.act;
    region_type_i   <= op.rtype;
    region_start_i  <= op.start;
    region_length_i <= op.len;
    free_address_i  <= op.addr;
    do @(posedge clk_i); while (!in_ready_o);
    apply_op(op, r);
    if (op.known) begin
      r.st = op.st; r.pa = op.pa; r.tp = op.tp;
    end
    pending_results.push_back(r);
    sent++;
  endtask

  task automatic write_kernel_end(input logic [19:0] v);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_valid_i              <= 1'b1;
    cfg_kernel_end_address_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    kernel_end = v;
  endtask

  task automatic run_session();
    int unsigned n_adds, n_ops, sel, idx;
    logic [63:0] st, ln;
    logic [31:0] ty, fa;
    send_op(mk_op(ACT_BEGIN, $urandom, {$urandom, $urandom}, {$urandom, $urandom}, $urandom));
    n_adds = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 6);
    for (int unsigned i = 0; i < n_adds; i++) begin
      ty = ($urandom_range(0, 9) == 0) ? $urandom : USABLE_TYPE;
      if ($urandom_range(0, 19) == 0) begin
        st = {$urandom, $urandom};
        ln = {$urandom, $urandom};
      end else begin
        st = 64'($urandom_range(0, 12'h7FF)) << 12;
        ln = 64'($urandom_range(0, 12'h300)) << 12;
        if ($urandom_range(0, 4) == 0) st += $urandom_range(0, 4095);
        if ($urandom_range(0, 3) == 0) ln += $urandom_range(0, 4095);
      end
      send_op(mk_op(ACT_ADD, ty, st, ln, $urandom));
    end
    send_op(mk_op(ACT_BUILD, $urandom, {$urandom, $urandom}, {$urandom, $urandom}, $urandom));
    n_ops = $urandom_range(4, 40);
    for (int unsigned i = 0; i < n_ops; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 50) begin
        send_op(mk_op(ACT_ALLOC, $urandom, {$urandom, $urandom}, {$urandom, $urandom},
                      $urandom));
      end else begin
        if (sel < 80 && granted_pages.size() != 0) begin
          idx = $urandom_range(0, granted_pages.size() - 1);
          fa = granted_pages[idx];
          if ($urandom_range(0, 1) == 0) granted_pages.delete(idx);
        end else if (sel < 95) begin
          fa = $urandom_range(0, 32'h900) << 12;
        end else begin
          fa = $urandom;
        end
        send_op(mk_op(ACT_FREE, $urandom, {$urandom, $urandom}, {$urandom, $urandom}, fa));
      end
    end
  endtask

  // result side: random stalls plus one long hold-off to back up the block
  int unsigned stall_left;
  bit          long_hold_done;

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at result %0d: %s", received, what);
  endtask

  always @(posedge clk_i) begin
    result_t e;
    if (out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending");
      end else begin
        e = pending_results.pop_front();
        if (status_o !== e.st)
          report_mismatch($sformatf("status exp %0d got %0d", e.st, status_o));
        if (page_address_o !== e.pa)
          report_mismatch($sformatf("page_address exp %h got %h", e.pa, page_address_o));
        if (total_pages_o !== e.tp)
          report_mismatch($sformatf("total_pages exp %0d got %0d", e.tp, total_pages_o));
      end
      received++;
    end
    if (stall_left != 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (!long_hold_done && received >= 400) begin
      long_hold_done = 1'b1;
      stall_left = 600;
      out_ready_i <= 1'b0;
    end else if ((received / 150) % 3 != 1 && $urandom_range(0, 7) == 0) begin
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 3);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  int unsigned idle_cycles;

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    op_t         directed [$];
    int unsigned next_cfg, cfg_step;
    kernel_end = 20'h20000;
    n_regions  = 0;
    top_addr   = LOW_LIMIT;
    page_lim   = 0;
    foreach (page_used[i]) page_used[i] = 1'b1;
    foreach (reg_lo[i]) begin
      reg_lo[i] = '0;
      reg_hi[i] = '0;
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    directed.push_back(mk_known(mk_op(ACT_ALLOC, '0, '0, '0, '0), ST_NO_MEM));
    directed.push_back(mk_known(mk_op(ACT_FREE, '0, '0, '0, '1), ST_UNALIGNED));
    directed.push_back(mk_known(mk_op(ACT_FREE, '1, '1, '1, '0), ST_BAD_ADDR));
    directed.push_back(mk_known(mk_op(3'd5, '0, '0, '0, '0), ST_OK));
    directed.push_back(mk_known(mk_op(3'd7, '1, '1, '1, '1), ST_OK));
    directed.push_back(mk_known(mk_op(ACT_BEGIN, '0, '0, '0, '0), ST_OK));
    directed.push_back(mk_known(mk_op(ACT_ADD, '1, 64'h20_0000, 64'h1000, '0), ST_OK));
    directed.push_back(mk_known(mk_op(ACT_ADD, USABLE_TYPE, '0, '0, '0), ST_OK));
    directed.push_back(mk_known(mk_op(ACT_ADD, USABLE_TYPE, '0, 64'h10_0000, '0), ST_OK));
    directed.push_back(mk_op(ACT_ADD, USABLE_TYPE, '0, 64'h20_0000, '0));
    directed.push_back(mk_op(ACT_ADD, USABLE_TYPE, 64'h30_0000, 64'h10_0000, '0));
    directed.push_back(mk_op(ACT_ADD, USABLE_TYPE, 64'hFFFF_FFFF_FFFF_F000, '1, '0));
    directed.push_back(mk_op(ACT_BUILD, '0, '0, '0, '0));
    directed.push_back(mk_op(ACT_ALLOC, '0, '0, '0, '0));
    directed.push_back(mk_op(ACT_ALLOC, '0, '0, '0, '0));
    directed.push_back(mk_op(ACT_FREE, '0, '0, '0, 32'h0010_1000));
    directed.push_back(mk_op(ACT_FREE, '0, '0, '0, 32'h0010_1000));
    directed.push_back(mk_op(ACT_FREE, '0, '0, '0, 32'h0020_0000));
    directed.push_back(mk_op(ACT_FREE, '0, '0, '0, 32'hFFFF_F000));
    directed.push_back(mk_op(ACT_FREE, '0, '0, '0, 32'h0010_0800));
    directed.push_back(mk_op(ACT_BEGIN, '0, '0, '0, '0));
    directed.push_back(mk_op(ACT_ALLOC, '0, '0, '0, '0));
    foreach (directed[i]) send_op(directed[i]);

    next_cfg = sent;
    cfg_step = 0;
    while (sent < N_ITEMS) begin
      if (sent >= next_cfg) begin
        case (cfg_step % 5)
          0: write_kernel_end(20'd0);
          1: write_kernel_end(20'd589823);
          2: write_kernel_end(20'($urandom_range(0, 589823)));
          3: write_kernel_end(20'h20000);
          default: write_kernel_end(20'($urandom_range(0, 20'h7FFFF)));
        endcase
        cfg_step++;
        next_cfg += 250;
      end
      if ($urandom_range(0, 3) != 0) begin
        run_session();
      end else begin
        repeat ($urandom_range(1, 6))
          send_op(mk_op(3'($urandom_range(0, 7)), $urandom, {$urandom, $urandom},
                        {$urandom, $urandom}, $urandom));
      end
    end
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);

    $display("%0d transactions in, %0d results, %0d config writes, %0d mismatches",
             sent, received, cfg_step, mismatches);
    $display("allocs %0d, frees %0d, rejected frees %0d, no-mem %0d, full %0d, stack %0d",
             n_alloc_ok, n_free_ok, n_reject, n_oom, n_full, n_stack);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
